// ===== src/ipd36_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd36_pkg
// Shared types and constants of the 36-bit IR pulse-distance decoder.
// ----------------------------------------------------------------------------
package ipd36_pkg;

  localparam int DUR_W  = 17;
  localparam int TOL_W  = 12;
  localparam int POS_W  = 7;
  localparam int NBITS  = 36;
  localparam int DATA_W = 32;
  localparam int MISC_W = NBITS - DATA_W;

  localparam logic [TOL_W-1:0] TOL_RESET = 12'd300;

  // nominal durations, 18-bit signed so that duration minus nominal cannot wrap
  localparam logic signed [DUR_W:0] HDR_MARK   = 18'sd4500;
  localparam logic signed [DUR_W:0] HDR_SPACE  = -18'sd4500;
  localparam logic signed [DUR_W:0] BIT_MARK   = 18'sd560;
  localparam logic signed [DUR_W:0] ONE_SPACE  = -18'sd1680;
  localparam logic signed [DUR_W:0] ZERO_SPACE = -18'sd560;

  localparam logic [POS_W-1:0] POS_MAX      = 7'd127;
  localparam logic [POS_W-1:0] POS_HDR_MARK = 7'd0;
  localparam logic [POS_W-1:0] POS_HDR_SPC  = 7'd1;
  localparam logic [POS_W-1:0] POS_FIRST    = 7'd2;
  localparam logic [POS_W-1:0] POS_GAP_MARK = 7'd34;
  localparam logic [POS_W-1:0] POS_GAP_SPC  = 7'd35;
  localparam logic [POS_W-1:0] POS_SECOND   = 7'd36;
  localparam logic [POS_W-1:0] POS_TRAILER  = 7'd76;
  localparam logic [POS_W-1:0] POS_LAST     = 7'd77;

  typedef enum logic [1:0] {
    ST_DECODED   = 2'd0,
    ST_NOT_PROTO = 2'd1,
    ST_BAD_BIT   = 2'd2
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data_word;
    logic [MISC_W-1:0] misc_bits;
  } result_t;

endpackage

// ===== src/ipd36_frame.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd36_frame
// Frame tracker: position count, header and bit checks, bit shifter, and the
// end-of-frame result for the item now being processed.
// ----------------------------------------------------------------------------
module ipd36_frame import ipd36_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic signed [DUR_W-1:0] duration,
  input  logic                    last_in_frame,
  input  logic [TOL_W-1:0]        match_tolerance,
  output result_t                 result
);

  logic [POS_W-1:0] frame_position;
  logic [NBITS-1:0] bit_shift;
  logic             header_failed;
  logic             bit_failed;

  logic [POS_W-1:0] frame_position_next;
  logic [NBITS-1:0] bit_shift_next;
  logic             header_failed_next;
  logic             bit_failed_next;

  function automatic logic near(input logic signed [DUR_W-1:0] v,
                                input logic signed [DUR_W:0]   nom,
                                input logic [TOL_W-1:0]        tol);
    logic signed [DUR_W:0] d;
    logic [DUR_W:0]        a;
    d = {v[DUR_W-1], v} - nom;
    a = d[DUR_W] ? (-d) : d;
    return a <= {{(DUR_W+1-TOL_W){1'b0}}, tol};
  endfunction

  logic m_hdr_mark, m_hdr_space, m_bit_mark, m_one, m_zero;
  logic in_bits, hdr_bad;

  always_comb begin
    m_hdr_mark  = near(duration, HDR_MARK, match_tolerance);
    m_hdr_space = near(duration, HDR_SPACE, match_tolerance);
    m_bit_mark  = near(duration, BIT_MARK, match_tolerance);
    m_one       = near(duration, ONE_SPACE, match_tolerance);
    m_zero      = near(duration, ZERO_SPACE, match_tolerance);

    hdr_bad = ((frame_position == POS_HDR_MARK) && !m_hdr_mark)  ||
              ((frame_position == POS_HDR_SPC)  && !m_hdr_space) ||
              ((frame_position == POS_FIRST)    && !m_bit_mark)  ||
              ((frame_position == POS_GAP_SPC)  && !m_hdr_space);

    in_bits = ((frame_position >= POS_FIRST) && (frame_position < POS_GAP_MARK)) ||
              ((frame_position >= POS_SECOND) && (frame_position < POS_TRAILER));

    header_failed_next = header_failed | hdr_bad;
    bit_failed_next    = bit_failed;
    bit_shift_next     = bit_shift;
    if (in_bits) begin
      if (!frame_position[0]) begin
        if (!m_bit_mark) bit_failed_next = 1'b1;
      end else begin
        // one wins when both space windows overlap
        bit_shift_next = {bit_shift[NBITS-2:0], m_one};
        if (!m_one && !m_zero) bit_failed_next = 1'b1;
      end
    end

    frame_position_next = (frame_position < POS_MAX) ? frame_position + 7'd1
                                                     : frame_position;

    result.status    = ST_DECODED;
    result.data_word = '0;
    result.misc_bits = '0;
    if ((frame_position != POS_LAST) || header_failed_next) begin
      result.status = ST_NOT_PROTO;
    end else if (bit_failed_next) begin
      result.status = ST_BAD_BIT;
    end else begin
      result.data_word = bit_shift_next[NBITS-1:MISC_W];
      result.misc_bits = bit_shift_next[MISC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      bit_shift      <= '0;
      header_failed  <= 1'b0;
      bit_failed     <= 1'b0;
    end else if (step) begin
      if (last_in_frame) begin
        frame_position <= '0;
        bit_shift      <= '0;
        header_failed  <= 1'b0;
        bit_failed     <= 1'b0;
      end else begin
        frame_position <= frame_position_next;
        bit_shift      <= bit_shift_next;
        header_failed  <= header_failed_next;
        bit_failed     <= bit_failed_next;
      end
    end
  end

endmodule

// ===== src/ir_pulse_36bit_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_36bit_decoder_core
// 36-bit IR pulse-distance decoder, streaming in and out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one signed duration per beat (mark > 0, space < 0, in us);
//   s_tlast marks the final duration of a captured frame.
//   m_* carries one result beat per frame, sent on the s_tlast beat:
//   status, 32 data bits (first received bit in bit 31) and 4 misc bits.
//   cfg_* writes match_tolerance; write only while the block is idle.
// Timing:
//   One beat accepted per cycle while the output is not stalled. A beat goes
//   into the input register, then through the frame logic into the result
//   register, which raises m_tvalid for the last beat of a frame.
// Stall:
//   A held result stops the input register from advancing; s_tready drops
//   only once the input register is full behind a stalled output.
// Reset:
//   rst clears frame state, empties both registers and sets the tolerance
//   back to 300 us.
// ----------------------------------------------------------------------------
module ir_pulse_36bit_decoder_core import ipd36_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,   // [16:0] duration, [23:17] zero
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [39:0]      m_tdata,   // [1:0] status, [33:2] data_word,
                                      // [37:34] misc_bits, [39:38] zero
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TOL_W-1:0] cfg_data
);

  logic                    in_valid;
  logic signed [DUR_W-1:0] in_duration;
  logic                    in_last;
  logic [TOL_W-1:0]        match_tolerance;
  logic                    step;
  result_t                 result;
  result_t                 out_result;

  assign step      = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= TOL_RESET;
    end else if (cfg_valid) begin
      match_tolerance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_duration <= s_tdata[DUR_W-1:0];
      in_last     <= s_tlast;
    end
  end

  ipd36_frame u_frame (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .duration        (in_duration),
    .last_in_frame   (in_last),
    .match_tolerance (match_tolerance),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      out_result <= result;
    end
  end

  assign m_tdata = {2'b00, out_result.misc_bits, out_result.data_word,
                    out_result.status};

endmodule

// ===== src/ipd36_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd36_checker
// Port-level checks of the IR decoder core, bound to the top level.
// ----------------------------------------------------------------------------
module ipd36_checker import ipd36_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present after reset");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_DECODED) || (m_tdata[1:0] == ST_NOT_PROTO) ||
                 (m_tdata[1:0] == ST_BAD_BIT))
    else $error("undefined status code");

  // data fields only carry bits on a decoded frame
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_DECODED) |-> (m_tdata[39:2] == '0))
    else $error("data bits set on a failed frame");

endmodule

bind ir_pulse_36bit_decoder_core ipd36_checker u_ipd36_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 36-bit IR pulse-distance decoder core.
// Frames of signed durations are streamed in with random gaps on both sides.
// A cycle-free model of the frame logic predicts one result per s_tlast beat,
// and every m_* beat is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import ipd36_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [TOL_W-1:0] cfg_data = '0;

  // decoder model state
  logic [TOL_W-1:0] tol_model = TOL_RESET;
  logic [POS_W-1:0] pos_model = '0;
  logic [NBITS-1:0] shift_model = '0;
  bit               hdr_fail_model = 1'b0;
  bit               bit_fail_model = 1'b0;

  result_t expected_results[$];
  int      pulse_q[$];

  int  mismatches = 0;
  int  pulses_sent = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;       // no idling on either side while set
  bit  hug_edges = 1'b0;   // jitter sits exactly on the window edges

  ir_pulse_36bit_decoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // decoder model
  // --------------------------------------------------------------------------
  function automatic bit near(int v, int nominal);
    int diff;
    diff = v - nominal;
    if (diff < 0) diff = -diff;
    return diff <= int'(tol_model);
  endfunction

  task automatic predict_pulse(logic signed [DUR_W-1:0] d, bit last);
    int      dur;
    bit      in_bits;
    result_t r;
    dur = d;
    if (pos_model == POS_HDR_MARK && !near(dur, HDR_MARK)) hdr_fail_model = 1'b1;
    if (pos_model == POS_HDR_SPC && !near(dur, HDR_SPACE)) hdr_fail_model = 1'b1;
    if (pos_model == POS_FIRST && !near(dur, BIT_MARK)) hdr_fail_model = 1'b1;
    if (pos_model == POS_GAP_SPC && !near(dur, HDR_SPACE)) hdr_fail_model = 1'b1;
    in_bits = (pos_model >= POS_FIRST && pos_model < POS_GAP_MARK) ||
              (pos_model >= POS_SECOND && pos_model < POS_TRAILER);
    if (in_bits) begin
      if (!pos_model[0]) begin
        if (!near(dur, BIT_MARK)) bit_fail_model = 1'b1;
      end else begin
        // one wins when the two space windows overlap
        if (near(dur, ONE_SPACE)) begin
          shift_model = {shift_model[NBITS-2:0], 1'b1};
        end else begin
          if (!near(dur, ZERO_SPACE)) bit_fail_model = 1'b1;
          shift_model = {shift_model[NBITS-2:0], 1'b0};
        end
      end
    end
    if (last) begin
      r = '0;
      if (pos_model != POS_LAST || hdr_fail_model) begin
        r.status = ST_NOT_PROTO;
      end else if (bit_fail_model) begin
        r.status = ST_BAD_BIT;
      end else begin
        r.status    = ST_DECODED;
        r.data_word = shift_model[NBITS-1:MISC_W];
        r.misc_bits = shift_model[MISC_W-1:0];
      end
      expected_results.insert(expected_results.size(), r);
      pos_model      = '0;
      shift_model    = '0;
      hdr_fail_model = 1'b0;
      bit_fail_model = 1'b0;
    end else if (pos_model != POS_MAX) begin
      pos_model = pos_model + 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // result checker and output backpressure
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result beat: m_tdata=%h", m_tdata);
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tdata[1:0] !== exp_r.status || m_tdata[33:2] !== exp_r.data_word ||
            m_tdata[37:34] !== exp_r.misc_bits || m_tdata[39:38] !== 2'b00) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display({"result mismatch: exp status=%0d data=%h misc=%h, ",
                      "got status=%0d data=%h misc=%h pad=%b"},
                     exp_r.status, exp_r.data_word, exp_r.misc_bits,
                     m_tdata[1:0], m_tdata[33:2], m_tdata[37:34], m_tdata[39:38]);
        end
      end
    end
    m_tready <= quiet || ($urandom_range(99) >= 12);
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_pulse(int dur, bit last);
    logic signed [DUR_W-1:0] d;
    d = dur[DUR_W-1:0];
    while (!quiet && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(24-DUR_W){1'b0}}, d};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    pulses_sent = pulses_sent + 1;
    predict_pulse(d, last);
  endtask

  task automatic send_frame();
    foreach (pulse_q[i]) send_pulse(pulse_q[i], i == pulse_q.size() - 1);
  endtask

  // let every pending result come out and the pipeline empty
  task automatic drain_decoder();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    drain_decoder();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_model = value;
  endtask

  function automatic int rand_dur();
    logic signed [DUR_W-1:0] r;
    r = DUR_W'($urandom);
    return int'(r);
  endfunction

  function automatic int wobble(int jit);
    if (hug_edges) return $urandom_range(1) ? jit : -jit;
    return int'($urandom_range(2 * jit)) - jit;
  endfunction

  task automatic add_pulse(int dur);
    pulse_q.insert(pulse_q.size(), dur);
  endtask

  // well-formed 78-pulse frame; code[35] is the first bit on the air
  task automatic build_frame(logic [NBITS-1:0] code, int jit);
    pulse_q.delete();
    add_pulse(int'(HDR_MARK) + wobble(jit));
    add_pulse(int'(HDR_SPACE) + wobble(jit));
    for (int k = 0; k < NBITS; k++) begin
      if (k == 16) begin
        add_pulse(rand_dur());   // gap mark is not checked
        add_pulse(int'(HDR_SPACE) + wobble(jit));
      end
      add_pulse(int'(BIT_MARK) + wobble(jit));
      add_pulse((code[NBITS-1-k] ? int'(ONE_SPACE) : int'(ZERO_SPACE)) + wobble(jit));
    end
    add_pulse(rand_dur());
    add_pulse(rand_dur());
  endtask

  task automatic corrupt_frame();
    int at;
    int off;
    at = $urandom_range(pulse_q.size() - 1);
    case ($urandom_range(3))
      0: pulse_q[at] = rand_dur();
      1: begin
        off = int'(tol_model) + 1 + $urandom_range(40);
        pulse_q[at] = pulse_q[at] + ($urandom_range(1) ? off : -off);
      end
      2: pulse_q.delete(at);
      default: pulse_q.insert($urandom_range(pulse_q.size()), rand_dur());
    endcase
  endtask

  function automatic logic [NBITS-1:0] rand_code();
    return {4'($urandom), 32'($urandom)};
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_pulse_extremes();
    send_pulse(65535, 1'b0);
    send_pulse(-65536, 1'b0);
    send_pulse(0, 1'b0);
    send_pulse(-1, 1'b1);
    send_pulse(-65536, 1'b1);
    send_pulse(65535, 1'b1);
  endtask

  task automatic test_clean_decode();
    build_frame(36'hF_0F0A_5C3E, 0);
    send_frame();
    build_frame('1, 0);
    send_frame();
    hug_edges = 1'b1;
    build_frame(36'h5_A5A5_A5A5, int'(tol_model));
    send_frame();
    hug_edges = 1'b0;
  endtask

  task automatic test_failure_priority();
    // header and bit failure in one frame: not-protocol wins
    build_frame(rand_code(), 0);
    pulse_q[0]  = 0;
    pulse_q[10] = -3000;
    send_frame();
    // bad bit space alone
    build_frame(rand_code(), 0);
    pulse_q[41] = -3000;
    send_frame();
    // gap space just outside the window
    build_frame(rand_code(), 0);
    pulse_q[POS_GAP_SPC] = int'(HDR_SPACE) - int'(tol_model) - 1;
    send_frame();
    // bad gap mark and trailer are not checked
    build_frame(rand_code(), 0);
    pulse_q[POS_GAP_MARK] = -65536;
    pulse_q[POS_TRAILER]  = 65535;
    send_frame();
  endtask

  task automatic test_overlap();
    write_tolerance(12'd700);
    // -1120 sits in both space windows and must read as one
    build_frame(36'h0_0000_0000, 0);
    for (int i = 3; i < 76; i += 2)
      if (i != int'(POS_GAP_SPC) && $urandom_range(1)) pulse_q[i] = -1120;
    send_frame();
    write_tolerance(TOL_RESET);
  endtask

  task automatic test_long_frame();
    build_frame(rand_code(), 0);
    repeat (60) add_pulse(rand_dur());
    send_frame();
  endtask

  task automatic test_random_traffic();
    logic [TOL_W-1:0] tol_plan[5];
    int start_pulses;
    int n;
    tol_plan[0] = TOL_RESET;
    tol_plan[1] = '0;
    tol_plan[2] = '1;
    tol_plan[3] = TOL_W'($urandom_range(4094, 1));
    tol_plan[4] = TOL_W'($urandom_range(600, 1));
    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(tol_plan[ph]);
      quiet = (ph == 0);
      start_pulses = pulses_sent;
      while (pulses_sent - start_pulses < 180) begin
        if (ph == 2 && pulses_sent - start_pulses > 60 && pulses_sent - start_pulses < 140)
          drain_decoder();
        n = $urandom_range(99);
        if (n < 60) begin
          build_frame(rand_code(), $urandom_range(int'(tol_model)));
        end else if (n < 85) begin
          build_frame(rand_code(), $urandom_range(int'(tol_model)));
          corrupt_frame();
        end else begin
          pulse_q.delete();
          repeat ($urandom_range(8, 1)) add_pulse(rand_dur());
        end
        send_frame();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_pulse_extremes();
    test_clean_decode();
    test_failure_priority();
    test_overlap();
    test_long_frame();
    test_random_traffic();
    drain_decoder();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== ir_pulse_36bit_decoder_core.f =====
src/ipd36_pkg.sv
src/ipd36_frame.sv
src/ir_pulse_36bit_decoder_core.sv
src/ipd36_checker.sv
tb/sv/tb.sv
